[rtl/core/resp_multibulk_request_parser_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the RESP multibulk request parser
// Shared forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef RESP_MULTIBULK_REQUEST_PARSER_ASSERT_SVH
`define RESP_MULTIBULK_REQUEST_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rpp: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rpp: next-cycle check failed");

`endif

[rtl/core/rpp_pkg.sv]
// ----------------------------------------------------------------------------
// rpp_pkg
// Types, byte codes, result codes and defaults of the RESP request parser.
// ----------------------------------------------------------------------------
package rpp_pkg;

    localparam int unsigned DEF_MAX_ARGS    = 1024;
    localparam int unsigned DEF_MAX_ARG_LEN = 1048576;

    localparam int unsigned ARGS_W   = 11;
    localparam int unsigned LEN_W    = 21;
    localparam int unsigned INDEX_W  = 10;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned CODE_W   = 3;

    localparam logic [LEN_W-1:0] ACC_MAX = {LEN_W{1'b1}};

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = LEN_W;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ARGS    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ARG_LEN = 1'b1;

    // Bytes of the protocol
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ARG_END = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MSG_END = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd3;

    // Error codes
    localparam logic [CODE_W-1:0] ERR_NONE   = 3'd0;
    localparam logic [CODE_W-1:0] ERR_PREFIX = 3'd1;
    localparam logic [CODE_W-1:0] ERR_COUNT  = 3'd2;
    localparam logic [CODE_W-1:0] ERR_LENGTH = 3'd3;
    localparam logic [CODE_W-1:0] ERR_TERM   = 3'd4;

    // Queue between the classifier and the parser; depth is a power of two.
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // A received byte together with its class.
    typedef struct packed {
        logic [7:0] data;
        logic       is_star;
        logic       is_dollar;
        logic       is_cr;
        logic       is_lf;
        logic       is_minus;
        logic       is_digit;
        logic [3:0] digit;
    } t_byte_cls;

    // Head of the queue as seen by the parser.
    typedef struct packed {
        logic      valid;
        t_byte_cls cls;
    } t_q_head;

endpackage

[rtl/core/rpp_in_if.sv]
// ----------------------------------------------------------------------------
// rpp_in_if
// Byte stream channel into the parser.
// ----------------------------------------------------------------------------
interface rpp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

[rtl/core/rpp_out_if.sv]
// ----------------------------------------------------------------------------
// rpp_out_if
// Result channel out of the parser.
// ----------------------------------------------------------------------------
interface rpp_out_if;
    logic                           valid;
    logic                           ready;
    logic [rpp_pkg::KIND_W-1:0]     kind;
    logic [7:0]                     payload_byte;
    logic [rpp_pkg::INDEX_W-1:0]    arg_index;
    logic [rpp_pkg::CODE_W-1:0]     error_code;

    modport source (output valid, output kind, output payload_byte, output arg_index,
                    output error_code, input ready);
    modport sink   (input valid, input kind, input payload_byte, input arg_index,
                    input error_code, output ready);
endinterface

[rtl/core/rpp_front.sv]
// ----------------------------------------------------------------------------
// rpp_front
// Accepts received bytes, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module rpp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rpp_in_if.sink            i_in,
    input  logic              i_pop,
    output rpp_pkg::t_q_head  o_head
);

    rpp_pkg::t_byte_cls                 w_cls;
    rpp_pkg::t_byte_cls                 r_mem [rpp_pkg::QUEUE_DEPTH];
    logic [rpp_pkg::QPTR_W-1:0]         r_wptr;
    logic [rpp_pkg::QPTR_W-1:0]         r_rptr;
    logic [rpp_pkg::QCNT_W-1:0]         r_count;
    logic                               w_push;

    always_comb begin
        w_cls.data      = i_in.data_byte;
        w_cls.is_star   = (i_in.data_byte == rpp_pkg::CH_STAR);
        w_cls.is_dollar = (i_in.data_byte == rpp_pkg::CH_DOLLAR);
        w_cls.is_cr     = (i_in.data_byte == rpp_pkg::CH_CR);
        w_cls.is_lf     = (i_in.data_byte == rpp_pkg::CH_LF);
        w_cls.is_minus  = (i_in.data_byte == rpp_pkg::CH_MINUS);
        w_cls.is_digit  = (i_in.data_byte >= rpp_pkg::CH_ZERO) &&
                          (i_in.data_byte <= rpp_pkg::CH_NINE);
        w_cls.digit     = i_in.data_byte[3:0];
    end

    assign i_in.ready = (r_count != rpp_pkg::QCNT_W'(rpp_pkg::QUEUE_DEPTH));
    assign w_push     = i_in.valid && i_in.ready;

    assign o_head.valid = (r_count != '0);
    assign o_head.cls   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= w_cls;
        end
    end

    // Pointers wrap on their own because the depth is a power of two.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (w_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/core/rpp_back.sv]
// ----------------------------------------------------------------------------
// rpp_back
// Request parser state machine with a registered result stage.
// ----------------------------------------------------------------------------
module rpp_back #(
    parameter int unsigned MAX_ARGS    = rpp_pkg::DEF_MAX_ARGS,
    parameter int unsigned MAX_ARG_LEN = rpp_pkg::DEF_MAX_ARG_LEN
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rpp_pkg::t_q_head                i_head,
    output logic                            o_pop,
    input  logic [rpp_pkg::ARGS_W-1:0]      i_max_args,
    input  logic [rpp_pkg::LEN_W-1:0]       i_max_arg_len,
    rpp_out_if.source                       o_out
);

    // The registers are narrower than the parameter range, so the
    // parameters are clamped to what the registers can hold.
    localparam int unsigned ARGS_CAP = (MAX_ARGS > (2 ** rpp_pkg::ARGS_W) - 1) ?
                                       (2 ** rpp_pkg::ARGS_W) - 1 : MAX_ARGS;
    localparam int unsigned LEN_CAP  = (MAX_ARG_LEN > (2 ** rpp_pkg::LEN_W) - 1) ?
                                       (2 ** rpp_pkg::LEN_W) - 1 : MAX_ARG_LEN;

    typedef enum logic [13:0] {
        PH_CNT_PREFIX = 14'h0001,
        PH_CNT_FIRST  = 14'h0002,
        PH_CNT_DIGITS = 14'h0004,
        PH_CNT_TAIL   = 14'h0008,
        PH_CNT_SKIP   = 14'h0010,
        PH_LEN_PREFIX = 14'h0020,
        PH_LEN_FIRST  = 14'h0040,
        PH_LEN_DIGITS = 14'h0080,
        PH_LEN_TAIL   = 14'h0100,
        PH_LEN_SKIP   = 14'h0200,
        PH_PAYLOAD    = 14'h0400,
        PH_TERM_CR    = 14'h0800,
        PH_TERM_LF    = 14'h1000,
        PH_DISCARD    = 14'h2000
    } t_phase;

    t_phase                             r_phase, n_phase;
    logic [rpp_pkg::LEN_W-1:0]          r_accum, n_accum;
    logic                               r_neg, n_neg;
    logic [rpp_pkg::ARGS_W-1:0]         r_args_exp, n_args_exp;
    logic [rpp_pkg::ARGS_W-1:0]         r_args_done, n_args_done;
    logic [rpp_pkg::LEN_W-1:0]          r_bytes_left, n_bytes_left;

    logic                               r_out_valid;
    logic [rpp_pkg::KIND_W-1:0]         r_kind;
    logic [7:0]                         r_payload;
    logic [rpp_pkg::INDEX_W-1:0]        r_index;
    logic [rpp_pkg::CODE_W-1:0]         r_code;

    rpp_pkg::t_byte_cls                 w_c;
    logic [rpp_pkg::ARGS_W-1:0]         w_lim_args;
    logic [rpp_pkg::LEN_W-1:0]          w_lim_len;
    logic [rpp_pkg::LEN_W+3:0]          w_acc_wide;
    logic [rpp_pkg::LEN_W-1:0]          w_acc_sat;
    logic [rpp_pkg::ARGS_W-1:0]         w_args_inc;
    logic                               w_num_neg;
    logic                               w_emit;
    logic [rpp_pkg::KIND_W-1:0]         w_kind;
    logic [7:0]                         w_payload;
    logic [rpp_pkg::CODE_W-1:0]         w_code;
    logic                               w_fail;
    logic                               w_resync;

    assign w_c = i_head.cls;

    assign w_lim_args = (i_max_args < rpp_pkg::ARGS_W'(ARGS_CAP)) ?
                        i_max_args : rpp_pkg::ARGS_W'(ARGS_CAP);
    assign w_lim_len  = (i_max_arg_len < rpp_pkg::LEN_W'(LEN_CAP)) ?
                        i_max_arg_len : rpp_pkg::LEN_W'(LEN_CAP);

    // Decimal accumulate, saturating at the all-ones value.
    assign w_acc_wide = ({4'b0, r_accum} << 3) + ({4'b0, r_accum} << 1) +
                        {{rpp_pkg::LEN_W{1'b0}}, w_c.digit};
    assign w_acc_sat  = (|w_acc_wide[rpp_pkg::LEN_W+3:rpp_pkg::LEN_W]) ?
                        rpp_pkg::ACC_MAX : w_acc_wide[rpp_pkg::LEN_W-1:0];

    assign w_args_inc = r_args_done + 1'b1;
    // A minus sign with no digits, or with zero, reads as zero.
    assign w_num_neg  = r_neg && (r_accum != '0);

    assign o_pop = i_head.valid && (!r_out_valid || o_out.ready);

    always_comb begin
        n_phase      = r_phase;
        n_accum      = r_accum;
        n_neg        = r_neg;
        n_args_exp   = r_args_exp;
        n_args_done  = r_args_done;
        n_bytes_left = r_bytes_left;
        w_emit       = 1'b0;
        w_kind       = rpp_pkg::KIND_PAYLOAD;
        w_payload    = '0;
        w_code       = rpp_pkg::ERR_NONE;
        w_fail       = 1'b0;
        w_resync     = 1'b0;

        unique case (r_phase)
            PH_CNT_PREFIX, PH_LEN_PREFIX: begin
                if ((r_phase == PH_CNT_PREFIX) ? !w_c.is_star : !w_c.is_dollar) begin
                    w_fail = 1'b1;
                    w_code = rpp_pkg::ERR_PREFIX;
                end else begin
                    n_accum = '0;
                    n_neg   = 1'b0;
                    n_phase = (r_phase == PH_CNT_PREFIX) ? PH_CNT_FIRST : PH_LEN_FIRST;
                end
            end
            PH_CNT_FIRST, PH_CNT_DIGITS, PH_CNT_TAIL: begin
                if (w_c.is_cr) begin
                    if (w_num_neg || (r_accum == '0) ||
                        (r_accum > {{(rpp_pkg::LEN_W-rpp_pkg::ARGS_W){1'b0}}, w_lim_args})) begin
                        w_fail = 1'b1;
                        w_code = rpp_pkg::ERR_COUNT;
                    end else begin
                        n_args_exp  = r_accum[rpp_pkg::ARGS_W-1:0];
                        n_args_done = '0;
                        n_phase     = PH_CNT_SKIP;
                    end
                end else if ((r_phase == PH_CNT_FIRST) && w_c.is_minus) begin
                    n_neg   = 1'b1;
                    n_phase = PH_CNT_DIGITS;
                end else if ((r_phase != PH_CNT_TAIL) && w_c.is_digit) begin
                    n_accum = w_acc_sat;
                    n_phase = PH_CNT_DIGITS;
                end else begin
                    n_phase = PH_CNT_TAIL;
                end
            end
            PH_CNT_SKIP: begin
                n_phase = PH_LEN_PREFIX;
            end
            PH_LEN_FIRST, PH_LEN_DIGITS, PH_LEN_TAIL: begin
                if (w_c.is_cr) begin
                    if (w_num_neg || (r_accum > w_lim_len)) begin
                        w_fail = 1'b1;
                        w_code = rpp_pkg::ERR_LENGTH;
                    end else begin
                        n_bytes_left = r_accum;
                        n_phase      = PH_LEN_SKIP;
                    end
                end else if ((r_phase == PH_LEN_FIRST) && w_c.is_minus) begin
                    n_neg   = 1'b1;
                    n_phase = PH_LEN_DIGITS;
                end else if ((r_phase != PH_LEN_TAIL) && w_c.is_digit) begin
                    n_accum = w_acc_sat;
                    n_phase = PH_LEN_DIGITS;
                end else begin
                    n_phase = PH_LEN_TAIL;
                end
            end
            PH_LEN_SKIP: begin
                n_phase = (r_bytes_left != '0) ? PH_PAYLOAD : PH_TERM_CR;
            end
            PH_PAYLOAD: begin
                w_emit       = 1'b1;
                w_kind       = rpp_pkg::KIND_PAYLOAD;
                w_payload    = w_c.data;
                n_bytes_left = r_bytes_left - 1'b1;
                if (r_bytes_left == rpp_pkg::LEN_W'(1)) begin
                    n_phase = PH_TERM_CR;
                end
            end
            PH_TERM_CR: begin
                if (!w_c.is_cr) begin
                    w_fail = 1'b1;
                    w_code = rpp_pkg::ERR_TERM;
                end else begin
                    n_phase = PH_TERM_LF;
                end
            end
            PH_TERM_LF: begin
                if (!w_c.is_lf) begin
                    w_fail = 1'b1;
                    w_code = rpp_pkg::ERR_TERM;
                end else if (w_args_inc == r_args_exp) begin
                    w_emit   = 1'b1;
                    w_kind   = rpp_pkg::KIND_MSG_END;
                    w_resync = 1'b1;
                end else begin
                    w_emit      = 1'b1;
                    w_kind      = rpp_pkg::KIND_ARG_END;
                    n_args_done = w_args_inc;
                    n_phase     = PH_LEN_PREFIX;
                end
            end
            PH_DISCARD: begin
                w_resync = w_c.is_lf;
            end
            default: begin
                w_resync = w_c.is_lf;
                n_phase  = PH_DISCARD;
            end
        endcase

        // An error on an LF byte resyncs at once; otherwise drop to the next LF.
        if (w_fail) begin
            w_emit    = 1'b1;
            w_kind    = rpp_pkg::KIND_ERROR;
            w_payload = '0;
            if (w_c.is_lf) begin
                w_resync = 1'b1;
            end else begin
                n_phase = PH_DISCARD;
            end
        end

        if (w_resync) begin
            n_phase      = PH_CNT_PREFIX;
            n_accum      = '0;
            n_neg        = 1'b0;
            n_args_exp   = '0;
            n_args_done  = '0;
            n_bytes_left = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_CNT_PREFIX;
            r_accum      <= '0;
            r_neg        <= 1'b0;
            r_args_exp   <= '0;
            r_args_done  <= '0;
            r_bytes_left <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase      <= n_phase;
                r_accum      <= n_accum;
                r_neg        <= n_neg;
                r_args_exp   <= n_args_exp;
                r_args_done  <= n_args_done;
                r_bytes_left <= n_bytes_left;
                r_out_valid  <= w_emit;
            end else if (o_out.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // The result index is the argument count before this byte's update.
    always_ff @(posedge i_clk) begin
        if (o_pop && w_emit) begin
            r_kind    <= w_kind;
            r_payload <= w_payload;
            r_index   <= r_args_done[rpp_pkg::INDEX_W-1:0];
            r_code    <= w_code;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_kind;
    assign o_out.payload_byte = r_payload;
    assign o_out.arg_index    = r_index;
    assign o_out.error_code   = r_code;

endmodule

[rtl/core/resp_multibulk_request_parser.sv]
// Result path: an accepted byte enters the byte queue; its result is
// written into the result register when the parser pops the byte.
// Throughput: one byte per cycle unless results wait; the parser updates
// once per byte; the two-entry queue absorbs output stalls until full.
// Reset: synchronous, active low; clears the queue and parser state and
// loads the default argument count and length limits.
// ----------------------------------------------------------------------------
// resp_multibulk_request_parser
// Top level: configuration registers, byte classifier queue and parser.
// ----------------------------------------------------------------------------
`include "resp_multibulk_request_parser_assert.svh"

module resp_multibulk_request_parser #(
    parameter int unsigned MAX_ARGS    = rpp_pkg::DEF_MAX_ARGS,
    parameter int unsigned MAX_ARG_LEN = rpp_pkg::DEF_MAX_ARG_LEN
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rpp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rpp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    rpp_in_if.sink                              i_in,
    rpp_out_if.source                           o_out
);

    logic [rpp_pkg::ARGS_W-1:0]     r_max_args;
    logic [rpp_pkg::LEN_W-1:0]      r_max_arg_len;
    rpp_pkg::t_q_head               w_head;
    logic                           w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_args    <= rpp_pkg::ARGS_W'(rpp_pkg::DEF_MAX_ARGS);
            r_max_arg_len <= rpp_pkg::LEN_W'(rpp_pkg::DEF_MAX_ARG_LEN);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rpp_pkg::CFG_MAX_ARGS:    r_max_args    <= i_cfg_data[rpp_pkg::ARGS_W-1:0];
                rpp_pkg::CFG_MAX_ARG_LEN: r_max_arg_len <= i_cfg_data[rpp_pkg::LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    rpp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    rpp_back #(
        .MAX_ARGS    (MAX_ARGS),
        .MAX_ARG_LEN (MAX_ARG_LEN)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .i_max_args    (r_max_args),
        .i_max_arg_len (r_max_arg_len),
        .o_out         (o_out)
    );

    // The parser only takes a byte that the queue holds.
    `RPP_ASSERT_SAME(a_pop_has_item, i_clk, i_rst_n, w_pop, w_head.valid)
    // Error results, and only those, carry an error code.
    `RPP_ASSERT_SAME(a_code_matches_kind, i_clk, i_rst_n, o_out.valid,
        (o_out.kind == rpp_pkg::KIND_ERROR) == (o_out.error_code != rpp_pkg::ERR_NONE))
    // Only payload results carry a data byte.
    `RPP_ASSERT_SAME(a_payload_only_data, i_clk, i_rst_n,
        o_out.valid && (o_out.kind != rpp_pkg::KIND_PAYLOAD), o_out.payload_byte == 8'h00)
    // A result that waits for the receiver stays valid and unchanged.
    `RPP_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n,
        o_out.valid && !o_out.ready, o_out.valid && $stable(o_out.kind))

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives a byte stream of RESP multibulk requests into the parser and checks
// each result against a cycle-free prediction of the parse, under several
// argument count and length limits and with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
    import rpp_pkg::*;

    typedef enum logic [3:0] {
        PH_CNT_PREFIX, PH_CNT_FIRST, PH_CNT_DIGITS, PH_CNT_TAIL, PH_CNT_SKIP,
        PH_LEN_PREFIX, PH_LEN_FIRST, PH_LEN_DIGITS, PH_LEN_TAIL, PH_LEN_SKIP,
        PH_PAYLOAD, PH_TERM_CR, PH_TERM_LF, PH_DISCARD
    } t_parse_phase;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [7:0]         payload;
        logic [INDEX_W-1:0] index;
        logic [CODE_W-1:0]  code;
    } t_parse_result;

    // In request text, these stand for the line-end bytes.
    localparam logic [7:0] TXT_CR = "|";
    localparam logic [7:0] TXT_LF = "/";

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_MAX_ARGS;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic [7:0]            in_data   = 8'h00;
    logic                  out_ready = 1'b0;

    rpp_in_if  in_if();
    rpp_out_if out_if();

    assign in_if.valid     = in_valid;
    assign in_if.data_byte = in_data;
    assign out_if.ready    = out_ready;

    resp_multibulk_request_parser i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // Predicted parser state and limits
    t_parse_phase     phase      = PH_CNT_PREFIX;
    logic [LEN_W-1:0] num_acc    = '0;
    logic             num_neg    = 1'b0;
    logic [ARGS_W-1:0] args_exp  = '0;
    logic [ARGS_W-1:0] args_done = '0;
    logic [LEN_W-1:0] bytes_left = '0;
    logic [ARGS_W-1:0] max_args_reg = ARGS_W'(DEF_MAX_ARGS);
    logic [LEN_W-1:0] max_len_reg   = LEN_W'(DEF_MAX_ARG_LEN);

    t_parse_result expected_q[$];
    logic [7:0]    byte_q[$];
    logic [7:0]    req[$];

    int unsigned error_count  = 0;
    int unsigned results_seen = 0;
    int unsigned hold_left    = 0;
    int unsigned hold_count   = 0;
    int unsigned in_gap       = 0;
    int unsigned out_gap      = 0;
    bit          in_steady    = 1'b0;
    bit          out_steady   = 1'b0;

    initial forever #4 i_clk = ~i_clk;

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #4000000;
        $display("testbench: errors");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at result %0d: %s", results_seen, msg);
        error_count++;
    endtask

    function automatic int unsigned count_limit();
        return (max_args_reg < DEF_MAX_ARGS) ? max_args_reg : DEF_MAX_ARGS;
    endfunction

    function automatic int unsigned len_limit();
        return (max_len_reg < DEF_MAX_ARG_LEN) ? max_len_reg : DEF_MAX_ARG_LEN;
    endfunction

    task automatic clear_parser();
        phase      = PH_CNT_PREFIX;
        num_acc    = '0;
        num_neg    = 1'b0;
        args_exp   = '0;
        args_done  = '0;
        bytes_left = '0;
    endtask

    task automatic push_result(input logic [KIND_W-1:0] kind, input logic [7:0] payload,
                               input logic [CODE_W-1:0] code);
        t_parse_result r;
        r.kind    = kind;
        r.payload = payload;
        r.index   = args_done[INDEX_W-1:0];
        r.code    = code;
        expected_q.push_back(r);
    endtask

    // An error is reported at once; an LF as the faulty byte resyncs at once.
    task automatic flag_error(input logic [7:0] b, input logic [CODE_W-1:0] code);
        push_result(KIND_ERROR, 8'h00, code);
        if (b == CH_LF) clear_parser();
        else phase = PH_DISCARD;
    endtask

    task automatic parse_byte(input logic [7:0] b);
        logic [63:0] grown;
        logic        is_count;
        logic        negative;
        is_count = (phase == PH_CNT_FIRST) || (phase == PH_CNT_DIGITS) ||
                   (phase == PH_CNT_TAIL);
        case (phase)
            PH_CNT_PREFIX, PH_LEN_PREFIX: begin
                if (b != ((phase == PH_CNT_PREFIX) ? CH_STAR : CH_DOLLAR)) begin
                    flag_error(b, ERR_PREFIX);
                end else begin
                    num_acc = '0;
                    num_neg = 1'b0;
                    if (phase == PH_CNT_PREFIX) phase = PH_CNT_FIRST;
                    else phase = PH_LEN_FIRST;
                end
            end
            PH_CNT_FIRST, PH_CNT_DIGITS, PH_CNT_TAIL,
            PH_LEN_FIRST, PH_LEN_DIGITS, PH_LEN_TAIL: begin
                if (b != CH_CR) begin
                    if ((phase == PH_CNT_FIRST || phase == PH_LEN_FIRST) && b == CH_MINUS) begin
                        num_neg = 1'b1;
                        if (is_count) phase = PH_CNT_DIGITS;
                        else phase = PH_LEN_DIGITS;
                    end else if (phase != PH_CNT_TAIL && phase != PH_LEN_TAIL &&
                                 b >= CH_ZERO && b <= CH_NINE) begin
                        grown   = 64'(num_acc) * 64'd10 + 64'(b - CH_ZERO);
                        num_acc = (grown > 64'(ACC_MAX)) ? ACC_MAX : grown[LEN_W-1:0];
                        if (is_count) phase = PH_CNT_DIGITS;
                        else phase = PH_LEN_DIGITS;
                    end else begin
                        if (is_count) phase = PH_CNT_TAIL;
                        else phase = PH_LEN_TAIL;
                    end
                end else begin
                    // A lone minus sign or minus zero reads as plain zero.
                    negative = num_neg && (num_acc != '0);
                    if (is_count) begin
                        if (negative || num_acc == '0 || num_acc > count_limit()) begin
                            flag_error(b, ERR_COUNT);
                        end else begin
                            args_exp  = num_acc[ARGS_W-1:0];
                            args_done = '0;
                            phase     = PH_CNT_SKIP;
                        end
                    end else if (negative || num_acc > len_limit()) begin
                        flag_error(b, ERR_LENGTH);
                    end else begin
                        bytes_left = num_acc;
                        phase      = PH_LEN_SKIP;
                    end
                end
            end
            PH_CNT_SKIP: phase = PH_LEN_PREFIX;
            PH_LEN_SKIP: begin
                if (bytes_left != '0) phase = PH_PAYLOAD;
                else phase = PH_TERM_CR;
            end
            PH_PAYLOAD: begin
                push_result(KIND_PAYLOAD, b, ERR_NONE);
                bytes_left = bytes_left - 1'b1;
                if (bytes_left == '0) phase = PH_TERM_CR;
            end
            PH_TERM_CR: begin
                if (b != CH_CR) flag_error(b, ERR_TERM);
                else phase = PH_TERM_LF;
            end
            PH_TERM_LF: begin
                if (b != CH_LF) begin
                    flag_error(b, ERR_TERM);
                end else if (ARGS_W'(args_done + 1'b1) == args_exp) begin
                    push_result(KIND_MSG_END, 8'h00, ERR_NONE);
                    clear_parser();
                end else begin
                    push_result(KIND_ARG_END, 8'h00, ERR_NONE);
                    args_done = args_done + 1'b1;
                    phase     = PH_LEN_PREFIX;
                end
            end
            default: begin
                if (b == CH_LF) clear_parser();
            end
        endcase
    endtask

    // Sender: offers the pending bytes in order, with a random pause after each item.
    always @(posedge i_clk) begin : byte_driver
        logic offer;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_if.ready) begin
                parse_byte(in_data);
                void'(byte_q.pop_front());
                in_gap = in_steady ? 0 : $urandom_range(0, 3);
            end
            if ($urandom_range(0, 99) == 0) in_steady = !in_steady;
            if (in_valid && !in_if.ready) begin
                offer = 1'b1;
            end else if (in_gap != 0) begin
                in_gap = in_gap - 1;
                offer  = 1'b0;
            end else begin
                offer = (byte_q.size() != 0);
            end
            if (offer) in_data <= byte_q[0];
            in_valid <= offer;
        end
    end

    // Receiver: checks every result, then stalls for a random number of cycles.
    always @(posedge i_clk) begin : result_monitor
        t_parse_result want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_if.valid && out_ready) begin
                results_seen <= results_seen + 1;
                if (expected_q.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    want = expected_q.pop_front();
                    if (out_if.kind !== want.kind)
                        report_mismatch($sformatf("kind %0d, expected %0d",
                                                  out_if.kind, want.kind));
                    if (out_if.payload_byte !== want.payload)
                        report_mismatch($sformatf("payload_byte %0h, expected %0h",
                                                  out_if.payload_byte, want.payload));
                    if (out_if.arg_index !== want.index)
                        report_mismatch($sformatf("arg_index %0d, expected %0d",
                                                  out_if.arg_index, want.index));
                    if (out_if.error_code !== want.code)
                        report_mismatch($sformatf("error_code %0d, expected %0d",
                                                  out_if.error_code, want.code));
                end
                out_gap = out_steady ? 0 : $urandom_range(0, 3);
            end
            if ($urandom_range(0, 99) == 0) out_steady = !out_steady;
            if (hold_left != 0) begin
                out_ready <= 1'b0;
            end else if (out_gap != 0) begin
                out_gap = out_gap - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Two long receiver stalls while the sender keeps offering, so the input backs up.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_count < 2 && results_seen >= 150 + 350 * hold_count) begin
            hold_left  <= 120;
            hold_count <= hold_count + 1;
        end
    end

    task automatic wait_idle();
        do @(negedge i_clk);
        while (byte_q.size() != 0 || in_valid || expected_q.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_limits(input int unsigned args_lim, input int unsigned len_lim);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_ARGS;
        cfg_data  <= CFG_DATA_W'(args_lim);
        @(posedge i_clk);
        cfg_index <= CFG_MAX_ARG_LEN;
        cfg_data  <= CFG_DATA_W'(len_lim);
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        max_args_reg = ARGS_W'(args_lim);
        max_len_reg  = LEN_W'(len_lim);
    endtask

    task automatic add_text(input string s);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (c == TXT_CR) req.push_back(CH_CR);
            else if (c == TXT_LF) req.push_back(CH_LF);
            else req.push_back(c);
        end
    endtask

    function automatic int unsigned send_request();
        int unsigned n;
        n = req.size();
        foreach (req[i]) byte_q.push_back(req[i]);
        req.delete();
        return n;
    endfunction

    // Header line with a random leading zero, minus zero, ignored tail and dropped byte.
    task automatic add_header(input logic [7:0] prefix, input int unsigned value);
        req.push_back(prefix);
        if (value == 0 && $urandom_range(0, 3) == 0) req.push_back(CH_MINUS);
        if ($urandom_range(0, 7) == 0) req.push_back(CH_ZERO);
        add_text($sformatf("%0d", value));
        if ($urandom_range(0, 7) == 0) add_text(" x9");
        req.push_back(CH_CR);
        if ($urandom_range(0, 3) == 0) req.push_back(8'($urandom_range(0, 255)));
        else req.push_back(CH_LF);
    endtask

    task automatic make_request();
        int unsigned pick;
        int unsigned nargs;
        int unsigned alen;
        int unsigned lim_c;
        int unsigned lim_l;
        int unsigned cut;
        lim_c = count_limit();
        lim_l = len_limit();
        pick  = $urandom_range(0, 99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 6)) req.push_back(8'($urandom_range(0, 255)));
            req.push_back(CH_LF);
        end else if (pick < 12) begin
            add_header(CH_STAR, lim_c + $urandom_range(1, 3));
        end else if (pick < 16) begin
            add_header(CH_STAR, 1);
            add_header(CH_DOLLAR, lim_l + $urandom_range(1, 3));
        end else begin
            if (lim_c == 0) nargs = $urandom_range(1, 3);
            else nargs = $urandom_range(1, (lim_c < 5) ? lim_c : 5);
            add_header(CH_STAR, nargs);
            repeat (nargs) begin
                alen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
                if (alen > lim_l) alen = lim_l;
                add_header(CH_DOLLAR, alen);
                repeat (alen) req.push_back(8'($urandom_range(0, 255)));
                req.push_back(CH_CR);
                req.push_back(CH_LF);
            end
            // Some well-formed requests get one byte corrupted or are cut short.
            if (pick < 30) begin
                cut = $urandom_range(0, req.size() - 1);
                if ($urandom_range(0, 1) == 0) begin
                    req[cut] = 8'($urandom_range(0, 255));
                end else begin
                    while (req.size() > cut) void'(req.pop_back());
                    req.push_back(CH_LF);
                end
            end
        end
    endtask

    task automatic run_phase(input int unsigned args_lim, input int unsigned len_lim,
                             input string opener, input int unsigned n_bytes);
        int unsigned sent;
        wait_idle();
        set_limits(args_lim, len_lim);
        add_text(opener);
        sent = send_request();
        while (sent < n_bytes) begin
            make_request();
            sent += send_request();
        end
    endtask

    initial begin : stimulus
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        set_limits(DEF_MAX_ARGS, DEF_MAX_ARG_LEN);

        // Single zero-length argument, then extreme payload bytes over two arguments.
        add_text("*1|/$0|/|/");
        add_text("*2|/$3|/");
        req.push_back(8'h00);
        req.push_back(8'hFF);
        add_text("a|/$1|/");
        req.push_back(8'h80);
        add_text("|/");
        // Bad prefix, and a bad prefix that is itself LF.
        add_text("x/");
        add_text("/");
        // Zero, negative, minus zero, bare minus, plus sign and space in the count.
        add_text("*0|/*-3|/*-0|/*-|/*+2|/* 2|/");
        // Leading zeros, ignored tail, arbitrary dropped bytes, minus zero lengths.
        add_text("*001 x9|Q$-|/|/*1|/$-0|/|/");
        // Count just over the limit, saturating count, count at the limit then bad prefix.
        add_text("*1025|/*99999999|/*1024|/#/");
        // Negative, just over the limit and saturating lengths.
        add_text("*1|/$-5|/*1|/$1048577|/*1|/$99999999|/");
        // Bad terminators: in place of CR, in place of LF, and an LF in place of CR.
        add_text("*1|/$1|/Ax/*1|/$1|/A|y/*1|/$1|/A/*1|/$2|/BC|/");
        // Count prefix where a length prefix belongs; payload holding CR and LF.
        add_text("*2|/$1|/Z|/*/");
        add_text("*1|X$2|Y|/|/");
        void'(send_request());

        run_phase(1, 0, "*1|/$0|/|/*2|/*1|/$1|/", 180);
        run_phase(3, 5, "*3|/$5|/abcde|/$0|/|/$6|/", 210);
        run_phase(2047, 2097151, "*1025|/*1|/$1048577|/", 210);
        run_phase(0, 2097151, "*1|/", 50);
        run_phase($urandom_range(1, 8), $urandom_range(0, 12), "", 230);
        run_phase(DEF_MAX_ARGS, DEF_MAX_ARG_LEN, "", 290);
        wait_idle();

        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

[resp_multibulk_request_parser.f]
+incdir+rtl/core
rtl/core/rpp_pkg.sv
rtl/core/rpp_in_if.sv
rtl/core/rpp_out_if.sv
rtl/core/rpp_front.sv
rtl/core/rpp_back.sv
rtl/core/resp_multibulk_request_parser.sv
dv/testbench.sv
